/* rtl/dfs_pkg.sv */
// Package for the dark frame subtraction block: widths, action codes and the
// command word type passed between front end, queue and back end. No dependencies.
package dfs_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned PIX_W          = 16;
  localparam int unsigned OUT_W          = 25;
  localparam int unsigned CFG_W          = 17;
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned COUNT_W        = 16;
  localparam int unsigned MASK_W         = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_PIXEL  = 2'd0,
    ACT_START  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    action_t           action;
    logic [PIX_W-1:0]  pixel;
  } cmd_t;

endpackage

/* rtl/dfs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/dfs_front.sv */
// Front end: accepts input words, drops unused codes, and feeds a short
// command queue towards the back end. Depends on dfs_pkg.
module dfs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [1:0]    s_tuser,
  input  logic [15:0]   s_tdata,
  output logic          q_valid,
  input  logic          q_pop,
  output dfs_pkg::cmd_t q_cmd
);
  import dfs_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  cmd_t            entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     fill;
  logic            push;
  logic            take;

  assign s_tready = (fill != (AW+1)'(DEPTH));
  assign take     = s_tvalid && s_tready;
  // Only meaningful actions go into the queue.
  assign push     = take && (action_t'(s_tuser) != ACT_NONE);
  assign q_valid  = (fill != '0);
  assign q_cmd    = entries[rd_ptr];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push) - (AW+1)'(q_pop);
    end
    if (push) begin
      entries[wr_ptr] <= '{action: action_t'(s_tuser), pixel: s_tdata};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (fill == (AW+1)'(DEPTH)) |-> !push)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command queue underflow");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> fill == $past(fill) + 1'b1)
    else $error("fill count slip");
`endif
endmodule

/* rtl/dfs_back.sv */
// Back end: subtracts the mask, accumulates sums while collecting and walks
// the frame with a serial divider on finish. Depends on dfs_pkg, dfs_ram.
module dfs_back #(
  parameter int unsigned MAX_PIXELS = dfs_pkg::MAX_PIXELS_DEF,
  parameter int unsigned FRAC_BITS  = dfs_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [16:0]   frame_pixels,
  input  logic          q_valid,
  output logic          q_pop,
  input  dfs_pkg::cmd_t q_cmd,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata,
  output logic          m_tlast
);
  import dfs_pkg::*;

  localparam int unsigned AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned NW   = AW + 1;
  localparam int unsigned DW   = SUM_W + FRAC_BITS;
  localparam int unsigned DCW  = $clog2(DW + 1);
  localparam int unsigned CLRW = AW + 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PIXEL = 7'b0000100,
    S_RD    = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WR    = 7'b0100000,
    S_SKIP  = 7'b1000000
  } state_t;

  state_t                 state;
  logic [NW-1:0]          n_eff;
  logic [NW-1:0]          pos;
  logic                   collecting;
  logic [COUNT_W-1:0]     frames;
  logic [PIX_W-1:0]       pix_r;
  logic [NW-1:0]          walk;
  logic [CLRW-1:0]        clr;
  logic [DW-1:0]          quo;
  logic [COUNT_W:0]       rem;
  logic [DCW-1:0]         dcnt;
  logic                   last_r;
  logic [COUNT_W:0]       rem_sh;
  logic [COUNT_W:0]       rem_sub;

  logic                   sum_we;
  logic [AW-1:0]          sum_waddr;
  logic [SUM_W-1:0]       sum_wdata;
  logic [AW-1:0]          rd_addr;
  logic [SUM_W-1:0]       sum_rdata;
  logic                   mask_we;
  logic [AW-1:0]          mask_waddr;
  logic [MASK_W-1:0]      mask_wdata;
  logic [MASK_W-1:0]      mask_rdata;
  logic [NW-1:0]          cur_pos;
  logic                   cur_last;
  logic [OUT_W-1:0]       shifted;

  // Effective frame size after clamping.
  always_comb begin
    if (frame_pixels == '0) begin
      n_eff = NW'(1);
    end else if (32'(frame_pixels) > MAX_PIXELS) begin
      n_eff = NW'(MAX_PIXELS);
    end else begin
      n_eff = NW'(frame_pixels);
    end
  end

  assign cur_pos  = (pos >= n_eff) ? '0 : pos;
  assign cur_last = (cur_pos == n_eff - 1'b1);
  assign rd_addr  = (state == S_IDLE) ? cur_pos[AW-1:0] : walk[AW-1:0];
  assign shifted  = OUT_W'({9'd0, pix_r} << FRAC_BITS);

  // One restoring divider step on the sum shifted up by the fraction bits.
  assign rem_sh  = {rem[COUNT_W-1:0], quo[DW-1]};
  assign rem_sub = rem_sh - {1'b0, frames};

  // Pop in idle when the result slot is free.
  assign q_pop = (state == S_IDLE) && q_valid && (!m_tvalid || m_tready);

  // Sum and mask write ports.
  always_comb begin
    sum_we     = 1'b0;
    sum_waddr  = pos[AW-1:0];
    sum_wdata  = '0;
    mask_we    = 1'b0;
    mask_waddr = walk[AW-1:0];
    mask_wdata = '0;
    if (state == S_CLEAR) begin
      mask_we    = 1'b1;
      mask_waddr = clr[AW-1:0];
    end else if (state == S_PIXEL && collecting && frames != COUNT_MAX) begin
      sum_we    = 1'b1;
      sum_wdata = (frames == '0) ? SUM_W'(pix_r) : sum_rdata + SUM_W'(pix_r);
    end else if (state == S_WR) begin
      mask_we = 1'b1;
      if (frames != '0) begin
        mask_wdata = (quo > DW'({MASK_W{1'b1}})) ? '1 : quo[MASK_W-1:0];
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      pos        <= '0;
      collecting <= 1'b0;
      frames     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CLRW'(MAX_PIXELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            case (q_cmd.action)
              ACT_PIXEL: begin
                pix_r  <= q_cmd.pixel;
                pos    <= cur_pos;
                last_r <= cur_last;
                state  <= S_PIXEL;
              end
              ACT_START: begin
                collecting <= 1'b1;
                frames     <= '0;
                pos        <= '0;
              end
              ACT_FINISH: begin
                if (collecting) begin
                  walk  <= '0;
                  state <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PIXEL: begin
          m_tvalid <= 1'b1;
          m_tlast  <= last_r;
          m_tdata  <= {7'd0, collecting ? shifted
                                        : shifted - OUT_W'(mask_rdata)};
          pos      <= last_r ? '0 : pos + 1'b1;
          if (collecting && last_r && frames != COUNT_MAX) begin
            frames <= frames + 1'b1;
          end
          state <= S_IDLE;
        end
        S_RD: begin
          state <= S_SKIP;
        end
        S_SKIP: begin
          quo   <= DW'(sum_rdata) << FRAC_BITS;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!rem_sub[COUNT_W]) begin
            rem <= rem_sub;
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DW-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCW'(DW - 1)) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          walk <= walk + 1'b1;
          if (walk == n_eff - 1'b1) begin
            collecting <= 1'b0;
            pos        <= '0;
            state      <= S_IDLE;
          end else begin
            state <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dfs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_PIXELS)) u_sum (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(rd_addr), .rdata(sum_rdata)
  );

  dfs_ram #(.WIDTH(MASK_W), .DEPTH(MAX_PIXELS)) u_mask (
    .clk(clk), .we(mask_we), .waddr(mask_waddr), .wdata(mask_wdata),
    .raddr(rd_addr), .rdata(mask_rdata)
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("pop outside idle");
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> walk < n_eff)
    else $error("walk beyond frame");
`endif
endmodule

/* rtl/dark_frame_subtract.sv */
// Dark frame subtraction top level. An accepted pixel passes the command queue
// and the back end pixel state to the registered result, one pixel at a time.
// A finish walks the frame pixel by pixel through read, skip, divide and write
// states (serial divider). After reset the mask is cleared over all MAX_PIXELS
// entries; words are queued meanwhile. Reset is synchronous, active high.
module dark_frame_subtract #(
  parameter int unsigned MAX_PIXELS         = dfs_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MASK_FRACTION_BITS = dfs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // action
  input  logic [15:0] s_tdata,   // pixel_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_value[24:0], zero fill
  output logic        m_tlast    // end_of_frame
);
  import dfs_pkg::*;

  logic [CFG_W-1:0] frame_pixels;
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;

  // Frame size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= CFG_W'(65536);
    end else if (cfg_we) begin
      frame_pixels <= cfg_wdata;
    end
  end

  dfs_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .s_tdata(s_tdata), .q_valid(q_valid), .q_pop(q_pop),
    .q_cmd(q_cmd)
  );

  dfs_back #(.MAX_PIXELS(MAX_PIXELS), .FRAC_BITS(MASK_FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .frame_pixels(frame_pixels), .q_valid(q_valid),
    .q_pop(q_pop), .q_cmd(q_cmd), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
  );
endmodule

/* test/tb_top.sv */
// Self-checking testbench for dark_frame_subtract: drives streamed pixel words,
// predicts results with a scoreboard class and checks every output word.
// Depends on dfs_pkg and the dark_frame_subtract RTL.
module tb_top;
  import dfs_pkg::*;

  localparam int unsigned FRAC      = FRAC_BITS_DEF;
  localparam int unsigned IDLE_LIMIT = 200000;

  // Expected output word.
  typedef struct {
    logic [OUT_W-1:0] value;
    logic             eof;
  } dfs_word_t;

  // Scoreboard: keeps its own copy of sums, mask and counters.
  class dark_frame_board;
    logic [SUM_W-1:0]   sums [MAX_PIXELS_DEF];
    logic [MASK_W-1:0]  mask [MAX_PIXELS_DEF];
    int unsigned        frames;
    int unsigned        position;
    logic [CFG_W-1:0]   frame_cfg;
    bit                 collecting;
    dfs_word_t          pending[$];
    int                 errors;

    function new();
      foreach (mask[i]) begin
        mask[i] = '0;
        sums[i] = '0;
      end
      frames = 0;
      position = 0;
      frame_cfg = 17'd65536;
      collecting = 0;
      errors = 0;
    endfunction

    function int unsigned frame_len();
      if (frame_cfg == 0) return 1;
      if (frame_cfg > MAX_PIXELS_DEF) return MAX_PIXELS_DEF;
      return frame_cfg;
    endfunction

    function void set_frame(logic [CFG_W-1:0] v);
      frame_cfg = v;
    endfunction

    // Note an accepted input word and queue any result it causes.
    function void note_word(action_t act, logic [PIX_W-1:0] pix);
      int unsigned n;
      bit          last;
      logic [63:0] q;
      dfs_word_t   w;
      n = frame_len();
      case (act)
        ACT_START: begin
          collecting = 1;
          frames = 0;
          position = 0;
        end
        ACT_FINISH: begin
          if (collecting) begin
            for (int unsigned i = 0; i < n; i++) begin
              q = 0;
              if (frames != 0) begin
                q = ({32'd0, sums[i]} << FRAC) / frames;
                if (q > 64'hFFFFFF) q = 64'hFFFFFF;
              end
              mask[i] = q[MASK_W-1:0];
            end
            collecting = 0;
            position = 0;
          end
        end
        ACT_PIXEL: begin
          if (position >= n) position = 0;
          last = (position == n - 1);
          if (collecting) begin
            w.value = {{(OUT_W-PIX_W-FRAC){1'b0}}, pix, {FRAC{1'b0}}};
            if (frames == 0) sums[position] = pix;
            else if (frames < COUNT_MAX) sums[position] += pix;
            if (last && frames < COUNT_MAX) frames++;
          end else begin
            w.value = {{(OUT_W-PIX_W-FRAC){1'b0}}, pix, {FRAC{1'b0}}}
                      - {{(OUT_W-MASK_W){1'b0}}, mask[position]};
          end
          w.eof = last;
          pending.push_back(w);
          position = last ? 0 : position + 1;
        end
        default: ;
      endcase
    endfunction

    // Compare an output word with the oldest expectation.
    function void check_word(logic [31:0] data, logic eof);
      dfs_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected output word: out_value %0h end_of_frame %0b",
               data[OUT_W-1:0], eof);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (data[OUT_W-1:0] !== w.value) begin
        $error("out_value: expected %0h, actual %0h", w.value, data[OUT_W-1:0]);
        errors++;
      end
      if (eof !== w.eof) begin
        $error("end_of_frame: expected %0b, actual %0b", w.eof, eof);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [1:0]        s_tuser;
  logic [PIX_W-1:0]  s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [31:0]       m_tdata;
  logic              m_tlast;

  dark_frame_board board;
  int unsigned     items_sent;
  int unsigned     idle_cycles;
  bit              long_hold_req;

  dark_frame_subtract uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // Clock, period 20.
  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // Output checking and the stall watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls per word, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    m_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 0;
        gap = 400;
      end else begin
        gap = draw_gap();
      end
      if (gap != 0) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Send one word with a random gap in front of it.
  task automatic send_word(action_t act, logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= act;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_word(act, pix);
    if (act != ACT_NONE) items_sent++;
    @(negedge clk);
  endtask

  // Wait until every result is in and any mask walk has finished.
  task automatic wait_idle();
    int unsigned n;
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    n = board.frame_len();
    if (n > 64) n = 64;
    repeat (60 + 45 * n) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_frame(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    board.set_frame(v);
    cfg_we    <= 0;
  endtask

  task automatic send_pixels(int unsigned count);
    repeat (count) send_word(ACT_PIXEL, PIX_W'($urandom_range(0, 65535)));
  endtask

  // Stimulus.
  initial begin
    int unsigned n;
    int unsigned frames;
    board = new();
    items_sent = 0;
    idle_cycles = 0;
    long_hold_req = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    s_tvalid = 0;
    s_tuser = ACT_PIXEL;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Default frame size, cleared mask, ignored codes.
    send_word(ACT_PIXEL, 16'h0000);
    send_word(ACT_PIXEL, 16'hFFFF);
    send_word(ACT_NONE, 16'h5555);
    send_word(ACT_FINISH, 16'h0);
    send_word(ACT_PIXEL, 16'hAAAA);

    // Zero frame size acts as one pixel; build a mask from extreme pixels.
    write_frame(17'd0);
    send_word(ACT_START, 16'h0);
    send_word(ACT_PIXEL, 16'hFFFF);
    send_word(ACT_PIXEL, 16'h0000);
    send_word(ACT_PIXEL, 16'hFFFF);
    send_word(ACT_FINISH, 16'h0);
    send_word(ACT_PIXEL, 16'h0000);
    send_word(ACT_PIXEL, 16'hFFFF);

    // Finish with no complete frame gives a zero mask; restart while collecting.
    write_frame(17'd4);
    send_word(ACT_START, 16'h0);
    send_word(ACT_PIXEL, 16'h1234);
    send_word(ACT_START, 16'h0);
    send_word(ACT_FINISH, 16'h0);
    send_pixels(3);

    // Shrink the frame while the position is past the new end.
    write_frame(17'd8);
    send_pixels(5);
    write_frame(17'd3);
    send_pixels(2);

    // Oversized frame setting acts as the largest frame.
    write_frame(17'h1FFFF);
    send_pixels(3);

    // Random phases; the first one carries the long receiver hold-off.
    write_frame(17'd5);
    long_hold_req = 1;
    send_pixels(80);
    while (items_sent < 1000) begin
      case ($urandom_range(0, 9))
        0: n = 0;
        1: n = 65536;
        2: n = 17'h1FFFF;
        3: n = 64;
        default: n = $urandom_range(1, 16);
      endcase
      write_frame(n[CFG_W-1:0]);
      if (board.frame_len() <= 64 && $urandom_range(0, 3) != 0) begin
        n = board.frame_len();
        frames = $urandom_range(0, (n > 16) ? 1 : 4);
        send_word(ACT_START, 16'h0);
        send_pixels(frames * n + $urandom_range(0, n));
        if ($urandom_range(0, 5) == 0) send_word(ACT_NONE, PIX_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 7) == 0) begin
          send_word(ACT_START, 16'h0);
          send_pixels($urandom_range(0, 2 * n));
        end
        send_word(ACT_FINISH, 16'h0);
        if ($urandom_range(0, 3) == 0) send_word(ACT_FINISH, 16'h0);
        send_pixels($urandom_range(n, 3 * n));
      end else begin
        send_pixels($urandom_range(5, 40));
        if ($urandom_range(0, 3) == 0) send_word(ACT_NONE, PIX_W'($urandom_range(0, 65535)));
      end
    end

    // Drain and finish.
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
